### src/three_timer_counter_unit_defines.svh
`ifndef THREE_TIMER_COUNTER_UNIT_DEFINES_SVH
`define THREE_TIMER_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ttc_pkg.sv
package ttc_pkg;

    typedef struct packed {
        logic command;
        logic capture_level;
        logic force_compare;
    } item_t;

    typedef struct packed {
        logic [6:0]  interrupt_pulses;
        logic [5:0]  match_flags;
        logic [7:0]  timer0_value;
        logic [15:0] timer1_value;
        logic [7:0]  timer2_value;
        logic [15:0] captured_value;
        logic        compare_output;
    } result_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_T0_CONTROL  = 3'd0,
        CFG_T0_COMPARES = 3'd1,
        CFG_T1_CONTROL  = 3'd2,
        CFG_T1_COMPARES = 3'd3,
        CFG_T2_CONTROL  = 3'd4,
        CFG_T2_COMPARES = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        OUT_NONE   = 2'd0,
        OUT_TOGGLE = 2'd1,
        OUT_CLEAR  = 2'd2,
        OUT_SET    = 2'd3
    } out_mode_t;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_CAPTURE = 1'b1;

    // Distinct raw prescale values that the two select tables draw on
    localparam int NUM_PRESCALE = 7;
    localparam int BASE_PRESCALE [NUM_PRESCALE] = '{1, 8, 32, 64, 128, 256, 1024};
    localparam int RES_W = 10;

    // Timer 0 / timer 1 table: 0, 1, 8, 64, 256, 1024, 0, 0
    function automatic logic t01_hit(input logic [2:0] sel,
                                     input logic [NUM_PRESCALE-1:0] hits);
        logic r;
        case (sel)
            3'd1:    r = hits[0];
            3'd2:    r = hits[1];
            3'd3:    r = hits[3];
            3'd4:    r = hits[5];
            3'd5:    r = hits[6];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Timer 2 table: 0, 1, 8, 32, 64, 128, 256, 1024
    function automatic logic t2_hit(input logic [2:0] sel,
                                    input logic [NUM_PRESCALE-1:0] hits);
        logic r;
        case (sel)
            3'd1:    r = hits[0];
            3'd2:    r = hits[1];
            3'd3:    r = hits[2];
            3'd4:    r = hits[3];
            3'd5:    r = hits[4];
            3'd6:    r = hits[5];
            3'd7:    r = hits[6];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### src/three_timer_counter_unit.sv
// Three timers (8, 16 and 8 bit) advanced by tick items, with compare match
// flags and interrupts, a timer 2 output pin and timer 1 input capture with an
// optional noise window. One item is taken every clock cycle while no stalled
// result holds it back; each item sits in an input register, and all counter,
// compare and capture updates are done in a single pass from the input register
// into the result register. A stalled result holds the input register
// and stalls the item channel. The prescalers are residue counters that
// follow the tick count, so no divider sits in the path. Configuration writes
// are always ready and take effect on the next item processed.
`include "three_timer_counter_unit_defines.svh"

module three_timer_counter_unit #(
    parameter int TICK_SCALE   = 8,
    parameter int NOISE_WINDOW = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  ttc_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ttc_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ttc_pkg::*;

    logic [4:0]  t0_control_reg;
    logic [15:0] t0_compares_reg;
    logic [6:0]  t1_control_reg;
    logic [31:0] t1_compares_reg;
    logic [7:0]  t2_control_reg;
    logic [15:0] t2_compares_reg;

    logic        item_valid_reg;
    item_t       item_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    logic [31:0] tick_count_reg;
    logic [7:0]  count_zero_reg;
    logic [15:0] count_one_reg;
    logic [7:0]  count_two_reg;
    logic [15:0] capture_latch_reg;
    logic        prev_level_reg;
    logic [31:0] last_change_reg;
    logic        output_level_reg;
    logic [RES_W-1:0] residue_reg [NUM_PRESCALE];

    logic [RES_W-1:0] residue_next [NUM_PRESCALE];
    logic [NUM_PRESCALE-1:0] prescale_hit;

    logic        advance;
    logic        tick_item;
    logic        capture_item;
    logic [31:0] tick_count_next;
    logic        tick_wrap;

    logic [7:0]  count_zero_next;
    logic [15:0] count_one_next;
    logic [7:0]  count_two_next;
    logic [7:0]  count_two_inc;
    logic [15:0] capture_latch_next;
    logic        prev_level_next;
    logic [31:0] last_change_next;
    logic        output_level_next;
    logic [5:0]  flags;
    logic [6:0]  pulses;
    logic        t0_tick;
    logic        t1_tick;
    logic        t2_tick;
    logic        match_a2;
    logic        capture_take;
    logic        rising_sel;
    logic [31:0] since_change;
    out_mode_t   out_mode;

    assign cfg_ready    = 1'b1;
    assign advance      = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = item_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign tick_item    = advance && (item_reg.command == CMD_TICK);
    assign capture_item = advance && (item_reg.command == CMD_CAPTURE);

    assign tick_count_next = tick_count_reg + 32'd1;
    assign tick_wrap       = (tick_count_next == '0);

    // Track tick_count modulo each prescale divided by TICK_SCALE; restart at tick wrap
    for (genvar g = 0; g < NUM_PRESCALE; g++) begin : g_prescale
        localparam int PRE = BASE_PRESCALE[g] / TICK_SCALE;

        always_comb
        begin
            if (PRE == 0)
            begin
                residue_next[g] = '0;
                prescale_hit[g] = 1'b0;
            end
            else
            begin
                if (tick_wrap || residue_reg[g] == RES_W'(PRE - 1))
                begin
                    residue_next[g] = '0;
                end
                else
                begin
                    residue_next[g] = residue_reg[g] + RES_W'(1);
                end
                prescale_hit[g] = (residue_next[g] == '0);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                residue_reg[g] <= '0;
            end
            else if (tick_item)
            begin
                residue_reg[g] <= residue_next[g];
            end
        end
    end

    assign t0_tick  = t01_hit(t0_control_reg[2:0], prescale_hit);
    assign t1_tick  = t01_hit(t1_control_reg[2:0], prescale_hit);
    assign t2_tick  = t2_hit(t2_control_reg[2:0], prescale_hit);
    assign out_mode = out_mode_t'(t2_control_reg[5:4]);
    assign rising_sel   = t1_control_reg[4];
    assign since_change = tick_count_reg - last_change_reg;
    assign count_two_inc = count_two_reg + 8'd1;

    always_comb
    begin
        flags              = '0;
        pulses             = '0;
        match_a2           = 1'b0;
        count_zero_next    = count_zero_reg;
        count_one_next     = count_one_reg;
        count_two_next     = count_two_reg;
        capture_latch_next = capture_latch_reg;
        prev_level_next    = prev_level_reg;
        last_change_next   = last_change_reg;
        output_level_next  = output_level_reg;
        capture_take       = 1'b0;

        if (item_reg.command == CMD_TICK)
        begin
            if (t0_tick)
            begin
                count_zero_next = count_zero_reg + 8'd1;
                flags[0] = (count_zero_next == t0_compares_reg[7:0]);
                flags[1] = (count_zero_next == t0_compares_reg[15:8]);
                pulses[0] = flags[0] && t0_control_reg[3];
                pulses[1] = flags[1] && t0_control_reg[4];
            end
            if (t1_tick)
            begin
                count_one_next = count_one_reg + 16'd1;
                flags[2] = (count_one_next == t1_compares_reg[15:0]);
                flags[3] = (count_one_next == t1_compares_reg[31:16]);
                pulses[2] = flags[2] && t1_control_reg[5];
                pulses[3] = flags[3] && t1_control_reg[6];
            end
            if (t2_tick)
            begin
                match_a2 = (count_two_inc == t2_compares_reg[7:0]);
                flags[4] = match_a2;
                flags[5] = (count_two_inc == t2_compares_reg[15:8]);
                pulses[4] = flags[4] && t2_control_reg[6];
                pulses[5] = flags[5] && t2_control_reg[7];
                if (t2_control_reg[3] && count_two_inc > t2_compares_reg[7:0])
                begin
                    count_two_next = '0;
                end
                else
                begin
                    count_two_next = count_two_inc;
                end
            end
            flags = flags & ~pulses[5:0];

            if (item_reg.force_compare || match_a2)
            begin
                case (out_mode)
                    OUT_SET:    output_level_next = 1'b1;
                    OUT_CLEAR:  output_level_next = 1'b0;
                    OUT_TOGGLE: output_level_next = !output_level_reg;
                    default:    output_level_next = output_level_reg;
                endcase
            end
        end
        else
        begin
            capture_take = (item_reg.capture_level != prev_level_reg) &&
                           (!t1_control_reg[3] || since_change >= 32'(NOISE_WINDOW));
            if (capture_take)
            begin
                capture_latch_next = count_one_reg;
                pulses[6] = (rising_sel == item_reg.capture_level);
                prev_level_next  = item_reg.capture_level;
                last_change_next = tick_count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_control_reg  <= '0;
            t0_compares_reg <= '0;
            t1_control_reg  <= '0;
            t1_compares_reg <= '0;
            t2_control_reg  <= '0;
            t2_compares_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_T0_CONTROL:  t0_control_reg  <= cfg_data[4:0];
                CFG_T0_COMPARES: t0_compares_reg <= cfg_data[15:0];
                CFG_T1_CONTROL:  t1_control_reg  <= cfg_data[6:0];
                CFG_T1_COMPARES: t1_compares_reg <= cfg_data[31:0];
                CFG_T2_CONTROL:  t2_control_reg  <= cfg_data[7:0];
                CFG_T2_COMPARES: t2_compares_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            count_zero_reg    <= '0;
            count_one_reg     <= '0;
            count_two_reg     <= '0;
            capture_latch_reg <= '0;
            prev_level_reg    <= 1'b0;
            last_change_reg   <= '0;
            output_level_reg  <= 1'b0;
        end
        else
        begin
            if (tick_item)
            begin
                tick_count_reg   <= tick_count_next;
                count_zero_reg   <= count_zero_next;
                count_one_reg    <= count_one_next;
                count_two_reg    <= count_two_next;
                output_level_reg <= output_level_next;
            end
            if (capture_item)
            begin
                capture_latch_reg <= capture_latch_next;
                prev_level_reg    <= prev_level_next;
                last_change_reg   <= last_change_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg.interrupt_pulses <= pulses;
            result_reg.match_flags      <= flags;
            result_reg.timer0_value     <= count_zero_next;
            result_reg.timer1_value     <= count_one_next;
            result_reg.timer2_value     <= count_two_next;
            result_reg.captured_value   <= capture_latch_next;
            result_reg.compare_output   <= output_level_next;
        end
    end

    `TTC_ASSERT_NEXT(a_capture_no_flags, capture_item,
        result_reg.match_flags == '0, "capture item reported compare flags")
    `TTC_ASSERT_NOW(a_flags_pulses_disjoint, result_valid_reg,
        (result_reg.match_flags & result_reg.interrupt_pulses[5:0]) == '0,
        "compare flag and its interrupt both set")
    `TTC_ASSERT_NEXT(a_tick_advance, tick_item,
        tick_count_reg == $past(tick_count_reg) + 32'd1, "tick count did not advance by one")
    `TTC_ASSERT_NEXT(a_capture_holds_timers, capture_item,
        $stable(count_zero_reg) && $stable(count_one_reg) && $stable(count_two_reg),
        "timer moved on a capture item")

endmodule

### tb/ttc_result_checker.sv
module ttc_result_checker #(
    parameter int TICK_SCALE   = 8,
    parameter int NOISE_WINDOW = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  ttc_pkg::item_t                  item,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  ttc_pkg::result_t                result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ttc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              results_checked,
    output int                              interrupt_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import ttc_pkg::*;

    localparam int unsigned T01_TABLE [8] = '{0, 1, 8, 64, 256, 1024, 0, 0};
    localparam int unsigned T2_TABLE  [8] = '{0, 1, 8, 32, 64, 128, 256, 1024};

    logic [4:0]  t0_ctrl = '0;
    logic [15:0] t0_cmp  = '0;
    logic [6:0]  t1_ctrl = '0;
    logic [31:0] t1_cmp  = '0;
    logic [7:0]  t2_ctrl = '0;
    logic [15:0] t2_cmp  = '0;

    logic [31:0] tick_count  = '0;
    logic [7:0]  cnt0        = '0;
    logic [15:0] cnt1        = '0;
    logic [7:0]  cnt2        = '0;
    logic [15:0] latch       = '0;
    logic        pin_prev    = 1'b0;
    logic [31:0] last_change = '0;
    logic        pin_out     = 1'b0;

    result_t expected_results [$];
    int      fail_total    = 0;
    int      checked_total = 0;
    int      irq_total     = 0;

    function automatic bit prescale_due(input int unsigned entry);
        int unsigned period;
        period = entry / TICK_SCALE;
        if (period == 0)
            return 1'b0;
        return (tick_count % period) == 0;
    endfunction

    function automatic result_t advance_timers(input item_t it);
        result_t     r;
        logic [6:0]  pulses;
        logic [5:0]  flags;
        logic        hit_a2;
        logic [31:0] since;
        pulses = '0;
        flags  = '0;
        hit_a2 = 1'b0;
        if (it.command == CMD_TICK)
        begin
            tick_count = tick_count + 32'd1;
            if (prescale_due(T01_TABLE[t0_ctrl[2:0]]))
            begin
                cnt0 = cnt0 + 8'd1;
                if (cnt0 == t0_cmp[7:0])
                    flags[0] = 1'b1;
                if (cnt0 == t0_cmp[15:8])
                    flags[1] = 1'b1;
                if (t0_ctrl[3])
                    pulses[0] = flags[0];
                if (t0_ctrl[4])
                    pulses[1] = flags[1];
            end
            if (prescale_due(T01_TABLE[t1_ctrl[2:0]]))
            begin
                cnt1 = cnt1 + 16'd1;
                if (cnt1 == t1_cmp[15:0])
                    flags[2] = 1'b1;
                if (cnt1 == t1_cmp[31:16])
                    flags[3] = 1'b1;
                if (t1_ctrl[5])
                    pulses[2] = flags[2];
                if (t1_ctrl[6])
                    pulses[3] = flags[3];
            end
            if (prescale_due(T2_TABLE[t2_ctrl[2:0]]))
            begin
                cnt2 = cnt2 + 8'd1;
                if (cnt2 == t2_cmp[7:0])
                begin
                    flags[4] = 1'b1;
                    hit_a2   = 1'b1;
                end
                if (cnt2 == t2_cmp[15:8])
                    flags[5] = 1'b1;
                // clear on compare acts after both compares
                if (t2_ctrl[3] && cnt2 > t2_cmp[7:0])
                    cnt2 = '0;
                if (t2_ctrl[6])
                    pulses[4] = flags[4];
                if (t2_ctrl[7])
                    pulses[5] = flags[5];
            end
            flags = flags & ~pulses[5:0];
            if (it.force_compare || hit_a2)
            begin
                case (out_mode_t'(t2_ctrl[5:4]))
                    OUT_SET:    pin_out = 1'b1;
                    OUT_CLEAR:  pin_out = 1'b0;
                    OUT_TOGGLE: pin_out = ~pin_out;
                    default:    ;
                endcase
            end
        end
        else
        begin
            since = tick_count - last_change;
            if (it.capture_level != pin_prev && (!t1_ctrl[3] || since >= NOISE_WINDOW))
            begin
                latch = cnt1;
                // bit 4 set selects the rising edge
                if (t1_ctrl[4] == it.capture_level)
                    pulses[6] = 1'b1;
                pin_prev    = it.capture_level;
                last_change = tick_count;
            end
        end
        r.interrupt_pulses = pulses;
        r.match_flags      = flags;
        r.timer0_value     = cnt0;
        r.timer1_value     = cnt1;
        r.timer2_value     = cnt2;
        r.captured_value   = latch;
        r.compare_output   = pin_out;
        return r;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            t0_ctrl     = '0;
            t0_cmp      = '0;
            t1_ctrl     = '0;
            t1_cmp      = '0;
            t2_ctrl     = '0;
            t2_cmp      = '0;
            tick_count  = '0;
            cnt0        = '0;
            cnt1        = '0;
            cnt2        = '0;
            latch       = '0;
            pin_prev    = 1'b0;
            last_change = '0;
            pin_out     = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_T0_CONTROL:  t0_ctrl = cfg_data[4:0];
                    CFG_T0_COMPARES: t0_cmp  = cfg_data[15:0];
                    CFG_T1_CONTROL:  t1_ctrl = cfg_data[6:0];
                    CFG_T1_COMPARES: t1_cmp  = cfg_data;
                    CFG_T2_CONTROL:  t2_ctrl = cfg_data[7:0];
                    CFG_T2_COMPARES: t2_cmp  = cfg_data[15:0];
                    default:         ;
                endcase
            end
            if (item_valid && !item_stall)
                expected_results.push_back(advance_timers(item));
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, got %h",
                             $time, result);
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("interrupt_pulses", 64'(want.interrupt_pulses),
                                64'(result.interrupt_pulses));
                    check_field("match_flags", 64'(want.match_flags),
                                64'(result.match_flags));
                    check_field("timer0_value", 64'(want.timer0_value),
                                64'(result.timer0_value));
                    check_field("timer1_value", 64'(want.timer1_value),
                                64'(result.timer1_value));
                    check_field("timer2_value", 64'(want.timer2_value),
                                64'(result.timer2_value));
                    check_field("captured_value", 64'(want.captured_value),
                                64'(result.captured_value));
                    check_field("compare_output", 64'(want.compare_output),
                                64'(result.compare_output));
                    checked_total++;
                    if (result.interrupt_pulses != '0)
                        irq_total++;
                end
            end
        end
        mismatches        <= fail_total;
        outstanding       <= expected_results.size();
        results_checked   <= checked_total;
        interrupt_results <= irq_total;
    end

endmodule

### tb/tb_three_timer_counter_unit.sv
module tb_three_timer_counter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ttc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TICK_SCALE     = 8;
    localparam int NOISE_WINDOW   = 20;
    localparam int NUM_REGS       = 6;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 64;
    localparam int IDLE_LIMIT     = 400;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd6;

    // prescale selects
    localparam logic [2:0] SEL_BELOW_SCALE = 3'd1;
    localparam logic [2:0] SEL_DIV1        = 3'd2;
    localparam logic [2:0] SEL_T01_DIV8    = 3'd3;
    localparam logic [2:0] SEL_T01_ZERO    = 3'd6;
    localparam logic [2:0] SEL_T2_DIV4     = 3'd3;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    int mismatches;
    int outstanding;
    int results_checked;
    int interrupt_results;

    logic [CFG_DATA_W-1:0] setting [NUM_REGS];
    result_t last_seen    = '0;
    bit      steady_in    = 1'b0;
    bit      steady_out   = 1'b0;
    int      hold_left    = 0;
    int      idle_cycles  = 0;
    int      items_sent   = 0;
    int      directed     = 0;
    int      settings_run = 0;

    three_timer_counter_unit #(
        .TICK_SCALE   (TICK_SCALE),
        .NOISE_WINDOW (NOISE_WINDOW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ttc_result_checker #(
        .TICK_SCALE   (TICK_SCALE),
        .NOISE_WINDOW (NOISE_WINDOW)
    ) checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .results_checked   (results_checked),
        .interrupt_results (interrupt_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // hold off each result for a random number of cycles unless steady_out is set
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            result_stall <= 1'b0;
        end
        else if (result_valid && !result_stall)
        begin
            last_seen <= result;
            if (steady_out)
            begin
                hold_left    <= 0;
                result_stall <= 1'b0;
            end
            else
            begin
                hold_left    <= $urandom_range(0, 8);
                result_stall <= ($urandom_range(0, 8) != 0);
            end
        end
        else if (hold_left > 1)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            hold_left    <= 0;
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("three_timer_counter_unit regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input item_t it);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic send_tick(input logic force_it);
        item_t it;
        it               = '0;
        it.command       = CMD_TICK;
        it.force_compare = force_it;
        send_item(it);
    endtask

    task automatic send_sample(input logic level);
        item_t it;
        it               = '0;
        it.command       = CMD_CAPTURE;
        it.capture_level = level;
        send_item(it);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input bit with_unused);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(i[CFG_INDEX_W-1:0], setting[i]);
        if (with_unused)
            write_reg(UNUSED_INDEX, '1);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    task automatic choose_settings(input int phase);
        foreach (setting[i])
            setting[i] = $urandom;
        if (phase == 0)
        begin
            foreach (setting[i])
                setting[i] = '1;
        end
        else if (phase == 1)
        begin
            foreach (setting[i])
                setting[i] = '0;
        end
        else if ($urandom_range(0, 4) != 0)
        begin
            // keep timers running with compares just ahead of the counts
            setting[CFG_T0_CONTROL][2:0] = $urandom_range(0, 1) ? SEL_DIV1 : SEL_T01_DIV8;
            setting[CFG_T1_CONTROL][2:0] = ($urandom_range(0, 3) != 0) ? SEL_DIV1
                                                                        : SEL_T01_DIV8;
            setting[CFG_T2_CONTROL][2:0] = $urandom_range(0, 1) ? SEL_DIV1 : SEL_T2_DIV4;
            setting[CFG_T0_COMPARES][7:0]   = last_seen.timer0_value + 8'($urandom_range(1, 30));
            setting[CFG_T0_COMPARES][15:8]  = last_seen.timer0_value + 8'($urandom_range(1, 30));
            setting[CFG_T1_COMPARES][15:0]  = last_seen.timer1_value
                                              + 16'($urandom_range(1, 40));
            setting[CFG_T1_COMPARES][31:16] = last_seen.timer1_value
                                              + 16'($urandom_range(1, 40));
            setting[CFG_T2_COMPARES][15:8]  = last_seen.timer2_value + 8'($urandom_range(1, 30));
            if (setting[CFG_T2_CONTROL][3])
                setting[CFG_T2_COMPARES][7:0] = 8'($urandom_range(2, 40));
            else
                setting[CFG_T2_COMPARES][7:0] = last_seen.timer2_value
                                                + 8'($urandom_range(1, 30));
        end
        apply_settings(phase == 0 || $urandom_range(0, 3) == 0);
    endtask

    function automatic item_t random_item(input int capture_pct);
        item_t it;
        it               = '0;
        it.command       = ($urandom_range(0, 99) < capture_pct) ? CMD_CAPTURE : CMD_TICK;
        it.capture_level = 1'($urandom_range(0, 1));
        it.force_compare = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    initial
    begin
        int capture_pct;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: all timers stopped, falling edge capture
        send_tick(1'b0);
        send_tick(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);

        // timer 0 below the tick scale, timer 1 fast with noise window,
        // timer 2 clearing on compare A with a toggling output
        settle();
        setting[CFG_T0_CONTROL]  = CFG_DATA_W'({1'b0, 1'b1, SEL_BELOW_SCALE});
        setting[CFG_T0_COMPARES] = '0;
        setting[CFG_T1_CONTROL]  = CFG_DATA_W'({1'b1, 1'b1, 1'b1, 1'b1, SEL_DIV1});
        setting[CFG_T1_COMPARES] = {16'd4, 16'd2};
        setting[CFG_T2_CONTROL]  = CFG_DATA_W'({1'b0, 1'b1, OUT_TOGGLE, 1'b1, SEL_DIV1});
        setting[CFG_T2_COMPARES] = CFG_DATA_W'({8'd1, 8'd3});
        apply_settings(1'b0);
        repeat (5) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_sample(1'b1);

        // timer 1 on a zero table entry, timer 2 never clearing at compare A of 255
        settle();
        setting[CFG_T0_CONTROL]  = CFG_DATA_W'({1'b0, 1'b1, SEL_DIV1});
        setting[CFG_T0_COMPARES] = CFG_DATA_W'({8'd2, 8'd1});
        setting[CFG_T1_CONTROL]  = CFG_DATA_W'({1'b0, 1'b0, 1'b0, 1'b0, SEL_T01_ZERO});
        setting[CFG_T2_CONTROL]  = CFG_DATA_W'({1'b1, 1'b1, OUT_SET, 1'b1, SEL_DIV1});
        setting[CFG_T2_COMPARES] = CFG_DATA_W'({8'd0, 8'd255});
        apply_settings(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        directed = items_sent;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            choose_settings(phase);
            steady_in   = ($urandom_range(0, 3) == 0);
            steady_out  = ($urandom_range(0, 3) == 0);
            capture_pct = $urandom_range(5, 45);
            repeat (PHASE_ITEMS) send_item(random_item(capture_pct));
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d items (%0d directed) through %0d register settings",
                 items_sent, directed, settings_run);
        $display("checked %0d results, %0d of them with interrupts taken",
                 results_checked, interrupt_results);
        if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("three_timer_counter_unit regression: pass");
        else
            $display("three_timer_counter_unit regression: fail");
        $finish;
    end

endmodule
